// ===== hdl/pairwise_particle_force_sum_assert.svh =====
// assertion macros used by the force-sum sequencer
`ifndef PAIRWISE_PARTICLE_FORCE_SUM_ASSERT_SVH
`define PAIRWISE_PARTICLE_FORCE_SUM_ASSERT_SVH

// condition holds in the same cycle
`define PPFS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ppfs assertion failed");

// condition holds in the next cycle
`define PPFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ppfs assertion failed");

`endif

// ===== hdl/ppfs_pkg.sv =====
package ppfs_pkg;

    localparam int MAX_PARTICLES_DEF = 8;

    localparam int POS_W   = 32;
    localparam int ACC_W   = 40;
    localparam int COEF_W  = 20;
    localparam int TERM_W  = 38;
    localparam int IDX_OUT_W = 6;

    // divider: 2^32 / m, one quotient bit per cycle
    localparam int DIV_STEPS = 33;
    localparam int DCNT_W    = 6;

    localparam logic [COEF_W-1:0] CUBE_RESET   = 20'd80908;
    localparam logic [COEF_W-1:0] SQUARE_RESET = 20'd428816;

    // register indexes
    localparam logic CFG_CUBE   = 1'b0;
    localparam logic CFG_SQUARE = 1'b1;

    // datapath commands
    typedef struct packed {
        logic pos_wr;
        logic latch_pi;
        logic diff;
        logic div_step;
        logic mul_sq;
        logic clip_sq;
        logic mul_cu;
        logic clip_cu;
        logic mul_a;
        logic mul_b;
        logic mag;
        logic acc_wr_i;
        logic acc_wr_j;
        logic out_load;
        logic out_last;
        logic set_clear;
    } ppfs_cmd_t;

    // datapath status
    typedef struct packed {
        logic d_zero;
        logic div_done;
    } ppfs_status_t;

endpackage

// ===== hdl/ppfs_ram.sv =====
module ppfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/ppfs_datapath.sv =====
module ppfs_datapath #(
    parameter int MAX_PARTICLES = ppfs_pkg::MAX_PARTICLES_DEF,
    localparam int IW = $clog2(MAX_PARTICLES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [19:0]         cfg_wdata,
    input  logic signed [31:0]  s_position,
    input  ppfs_pkg::ppfs_cmd_t cmd,
    input  logic [IW-1:0]       pos_addr,
    input  logic [IW-1:0]       acc_addr,
    output ppfs_pkg::ppfs_status_t status,
    output logic [5:0]          m_particle_index,
    output logic signed [31:0]  m_force_res,
    output logic                m_saturated,
    output logic                m_coincident_error,
    output logic                m_last_force
);

    logic [19:0] cube_reg;
    logic [19:0] square_reg;

    logic [31:0] pos_rdata;
    logic [31:0] pi_reg;
    logic [32:0] d;
    logic [31:0] d_abs;
    logic        d_neg_reg;
    logic [31:0] m_reg;
    logic [31:0] rem_reg;
    logic [32:0] q_reg;
    logic [5:0]  dcnt_reg;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [32:0] rem_sub;

    logic        rm_over;
    logic [30:0] rm_val;
    logic [30:0] rm_reg;
    logic [30:0] sq_reg;
    logic [30:0] cu_reg;
    logic [34:0] a_reg;
    logic [63:0] prod_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic        prod_over;
    logic [30:0] prod_clip;
    logic        clip_reg;
    logic [36:0] mag;
    logic [37:0] t_reg;

    logic [39:0] acc_rdata;
    logic [39:0] acc_old;
    logic [37:0] addend;
    logic [40:0] sum;
    logic        sum_sat;
    logic [39:0] acc_wdata;
    logic        acc_we;
    logic        out_clamp;

    logic [MAX_PARTICLES-1:0] accv_reg;
    logic [MAX_PARTICLES-1:0] clipv_reg;
    logic                     err_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cube_reg   <= ppfs_pkg::CUBE_RESET;
            square_reg <= ppfs_pkg::SQUARE_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                ppfs_pkg::CFG_CUBE:   cube_reg   <= cfg_wdata;
                ppfs_pkg::CFG_SQUARE: square_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // position store
    ppfs_ram #(.WIDTH(ppfs_pkg::POS_W), .DEPTH(MAX_PARTICLES)) u_pos_ram (
        .clk     (aclk),
        .wr_en   (cmd.pos_wr),
        .wr_addr (pos_addr),
        .wr_data (s_position),
        .rd_addr (pos_addr),
        .rd_data (pos_rdata)
    );

    // difference and its magnitude
    assign d     = {pi_reg[31], pi_reg} - {pos_rdata[31], pos_rdata};
    assign d_abs = d[32] ? 32'(-d) : d[31:0];
    assign status.d_zero = (d == 33'd0);

    // restoring divider step, dividend is 2^32
    assign rem_sh  = {rem_reg, (dcnt_reg == 6'd0)};
    assign rem_ge  = (rem_sh >= {1'b0, m_reg});
    assign rem_sub = rem_sh - {1'b0, m_reg};
    assign status.div_done = (dcnt_reg == 6'(ppfs_pkg::DIV_STEPS - 1));

    // reciprocal clipped to 31 bits
    assign rm_over = q_reg[32] | q_reg[31];
    assign rm_val  = rm_over ? 31'h7FFF_FFFF : q_reg[30:0];

    // shared multiplier operand select
    always_comb begin
        op_a = 32'd0;
        op_b = 32'd0;
        if (cmd.mul_sq) begin
            op_a = {1'b0, rm_val};
            op_b = {1'b0, rm_val};
        end else if (cmd.mul_cu) begin
            op_a = {1'b0, sq_reg};
            op_b = {1'b0, rm_reg};
        end else if (cmd.mul_a) begin
            op_a = {12'd0, cube_reg};
            op_b = {1'b0, cu_reg};
        end else if (cmd.mul_b) begin
            op_a = {12'd0, square_reg};
            op_b = {1'b0, sq_reg};
        end
    end

    assign prod_over = |prod_reg[63:47];
    assign prod_clip = prod_over ? 31'h7FFF_FFFF : prod_reg[46:16];
    assign mag = {2'b00, a_reg} - {2'b00, prod_reg[50:16]};

    // pair term pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_pi) begin
            pi_reg <= pos_rdata;
        end
        if (cmd.diff) begin
            d_neg_reg <= d[32];
            m_reg     <= d_abs;
            rem_reg   <= 32'd0;
            q_reg     <= 33'd0;
            dcnt_reg  <= 6'd0;
            clip_reg  <= 1'b0;
        end
        if (cmd.div_step) begin
            rem_reg  <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
            q_reg    <= {q_reg[31:0], rem_ge};
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        if (cmd.mul_sq) begin
            rm_reg   <= rm_val;
            clip_reg <= clip_reg | rm_over;
        end
        if (cmd.mul_sq || cmd.mul_cu || cmd.mul_a || cmd.mul_b) begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.clip_sq) begin
            sq_reg   <= prod_clip;
            clip_reg <= clip_reg | prod_over;
        end
        if (cmd.clip_cu) begin
            cu_reg   <= prod_clip;
            clip_reg <= clip_reg | prod_over;
        end
        if (cmd.mul_b) begin
            a_reg <= prod_reg[50:16];
        end
        if (cmd.mag) begin
            t_reg <= d_neg_reg ? -{mag[36], mag} : {mag[36], mag};
        end
    end

    // force accumulators, read then written back
    assign acc_we = cmd.acc_wr_i | cmd.acc_wr_j;

    ppfs_ram #(.WIDTH(ppfs_pkg::ACC_W), .DEPTH(MAX_PARTICLES)) u_acc_ram (
        .clk     (aclk),
        .wr_en   (acc_we),
        .wr_addr (acc_addr),
        .wr_data (acc_wdata),
        .rd_addr (acc_addr),
        .rd_data (acc_rdata)
    );

    assign acc_old = accv_reg[acc_addr] ? acc_rdata : 40'd0;
    assign addend  = cmd.acc_wr_j ? -t_reg : t_reg;
    assign sum     = {acc_old[39], acc_old} + {{3{addend[37]}}, addend};
    assign sum_sat = sum[40] ^ sum[39];

    always_comb begin
        acc_wdata = sum[39:0];
        if (sum_sat) begin
            acc_wdata = sum[40] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
        end
    end

    // valid bits, clip flags and coincidence flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accv_reg  <= '0;
            clipv_reg <= '0;
            err_reg   <= 1'b0;
        end else if (cmd.set_clear) begin
            accv_reg  <= '0;
            clipv_reg <= '0;
            err_reg   <= 1'b0;
        end else begin
            if (cmd.diff && status.d_zero) begin
                err_reg <= 1'b1;
            end
            if (acc_we) begin
                accv_reg[acc_addr]  <= 1'b1;
                clipv_reg[acc_addr] <= clipv_reg[acc_addr] | clip_reg | sum_sat;
            end
        end
    end

    // output register with clamp to 32 bits
    assign out_clamp = !((acc_old[39:31] == 9'h000) || (acc_old[39:31] == 9'h1FF));

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_particle_index   <= 6'(acc_addr);
            m_force_res        <= out_clamp ? (acc_old[39] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                            : acc_old[31:0];
            m_saturated        <= clipv_reg[acc_addr] | out_clamp;
            m_coincident_error <= err_reg;
            m_last_force       <= cmd.out_last;
        end
    end

endmodule

// ===== hdl/ppfs_ctrl.sv =====
`include "pairwise_particle_force_sum_assert.svh"

module ppfs_ctrl #(
    parameter int MAX_PARTICLES = ppfs_pkg::MAX_PARTICLES_DEF,
    localparam int IW = $clog2(MAX_PARTICLES),
    localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_last_particle,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  ppfs_pkg::ppfs_status_t status,
    output ppfs_pkg::ppfs_cmd_t    cmd,
    output logic [IW-1:0]          pos_addr,
    output logic [IW-1:0]          acc_addr
);

    typedef enum logic [18:0] {
        ST_LOAD   = 19'h00001,
        ST_RD_I   = 19'h00002,
        ST_RD_J   = 19'h00004,
        ST_DIFF   = 19'h00008,
        ST_DIV    = 19'h00010,
        ST_MSQ    = 19'h00020,
        ST_CSQ    = 19'h00040,
        ST_MCU    = 19'h00080,
        ST_CCU    = 19'h00100,
        ST_MA     = 19'h00200,
        ST_MB     = 19'h00400,
        ST_MAG    = 19'h00800,
        ST_ACC_RI = 19'h01000,
        ST_ACC_WI = 19'h02000,
        ST_ACC_RJ = 19'h04000,
        ST_ACC_WJ = 19'h08000,
        ST_OUT_RD = 19'h10000,
        ST_OUT_LD = 19'h20000,
        ST_OUT    = 19'h40000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic          s_xfer;
    logic          m_xfer;
    logic          store_ok;
    logic          more_j;
    logic          more_i;
    logic          k_last;

    assign s_xfer   = s_valid & s_ready;
    assign m_xfer   = m_valid & m_ready;
    assign store_ok = (count_reg < CW'(MAX_PARTICLES));
    assign more_j   = ((CW'(j_reg) + CW'(1)) < CW'(i_reg));
    assign more_i   = ((CW'(i_reg) + CW'(1)) < count_reg);
    assign k_last   = ((CW'(k_reg) + CW'(1)) == count_reg);

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_OUT);

    // state and loop indexes
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_xfer) begin
                    if (store_ok) begin
                        count_next = count_reg + CW'(1);
                    end
                    if (s_last_particle) begin
                        i_next = IW'(1);
                        j_next = '0;
                        k_next = '0;
                        if (store_ok ? (count_reg == '0) : 1'b0) begin
                            state_next = ST_OUT_RD;
                        end else begin
                            state_next = ST_RD_I;
                        end
                    end
                end
            end
            ST_RD_I:   state_next = ST_RD_J;
            ST_RD_J:   state_next = ST_DIFF;
            ST_DIFF:   state_next = status.d_zero ? ST_ACC_WJ : ST_DIV;
            ST_DIV:    state_next = status.div_done ? ST_MSQ : ST_DIV;
            ST_MSQ:    state_next = ST_CSQ;
            ST_CSQ:    state_next = ST_MCU;
            ST_MCU:    state_next = ST_CCU;
            ST_CCU:    state_next = ST_MA;
            ST_MA:     state_next = ST_MB;
            ST_MB:     state_next = ST_MAG;
            ST_MAG:    state_next = ST_ACC_RI;
            ST_ACC_RI: state_next = ST_ACC_WI;
            ST_ACC_WI: state_next = ST_ACC_RJ;
            ST_ACC_RJ: state_next = ST_ACC_WJ;
            ST_ACC_WJ: begin
                // next pair, or on to the results
                if (more_j) begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_RD_I;
                end else if (more_i) begin
                    i_next     = i_reg + IW'(1);
                    j_next     = '0;
                    state_next = ST_RD_I;
                end else begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT_LD;
            ST_OUT_LD: state_next = ST_OUT;
            ST_OUT: begin
                if (m_xfer) begin
                    if (k_last) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + IW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // command decode
    always_comb begin
        cmd          = '0;
        cmd.pos_wr   = (state_reg == ST_LOAD) & s_xfer & store_ok;
        cmd.latch_pi = (state_reg == ST_RD_J);
        cmd.diff     = (state_reg == ST_DIFF);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.mul_sq   = (state_reg == ST_MSQ);
        cmd.clip_sq  = (state_reg == ST_CSQ);
        cmd.mul_cu   = (state_reg == ST_MCU);
        cmd.clip_cu  = (state_reg == ST_CCU);
        cmd.mul_a    = (state_reg == ST_MA);
        cmd.mul_b    = (state_reg == ST_MB);
        cmd.mag      = (state_reg == ST_MAG);
        cmd.acc_wr_i = (state_reg == ST_ACC_WI);
        cmd.acc_wr_j = (state_reg == ST_ACC_WJ) & !status.d_zero;
        cmd.out_load = (state_reg == ST_OUT_LD);
        cmd.out_last = k_last;
        cmd.set_clear = (state_reg == ST_OUT) & m_xfer & k_last;
    end

    // status.d_zero holds from ST_DIFF to ST_ACC_WJ, as p_i is latched
    // and the position store keeps reading p_j

    always_comb begin
        pos_addr = j_reg;
        if (state_reg == ST_LOAD) begin
            pos_addr = count_reg[IW-1:0];
        end else if (state_reg == ST_RD_I) begin
            pos_addr = i_reg;
        end
    end

    always_comb begin
        acc_addr = k_reg;
        if ((state_reg == ST_ACC_RI) || (state_reg == ST_ACC_WI)) begin
            acc_addr = i_reg;
        end else if ((state_reg == ST_ACC_RJ) || (state_reg == ST_ACC_WJ)) begin
            acc_addr = j_reg;
        end
    end

    `PPFS_ASSERT_SAME(a_no_overlap, aclk, aresetn, s_ready, !m_valid)
    `PPFS_ASSERT_NEXT(a_last_closes, aclk, aresetn, s_xfer && s_last_particle, !s_ready)
    `PPFS_ASSERT_NEXT(a_set_done, aclk, aresetn, m_xfer && k_last, s_ready)
    `PPFS_ASSERT_SAME(a_pair_order, aclk, aresetn,
        (state_reg == ST_DIFF) || (state_reg == ST_DIV), j_reg < i_reg)

endmodule

// ===== hdl/pairwise_particle_force_sum.sv =====
// channel   | handshake          | payload
// config    | cfg_write          | cfg_index, cfg_wdata
// input     | s_valid / s_ready  | s_position, s_last_particle
// result    | m_valid / m_ready  | m_particle_index, m_force_res, m_saturated,
//           |                    | m_coincident_error, m_last_force
//
// positions load back to back while s_valid is high; the last one starts the pair sweep
// each pair is read, differenced, divided into 2^32 for its reciprocal, then squared,
// cubed and scaled on the shared multiplier; a pair of equal positions skips the arithmetic
// each result is read, loaded and held in ST_OUT until m_ready; no input is taken meanwhile
// aresetn is synchronous, active low, and leaves the block ready for a new set
module pairwise_particle_force_sum #(
    parameter int MAX_PARTICLES = ppfs_pkg::MAX_PARTICLES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [19:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_position,
    input  logic                s_last_particle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [5:0]          m_particle_index,
    output logic signed [31:0]  m_force_res,
    output logic                m_saturated,
    output logic                m_coincident_error,
    output logic                m_last_force
);

    localparam int IW = $clog2(MAX_PARTICLES);

    ppfs_pkg::ppfs_cmd_t    cmd;
    ppfs_pkg::ppfs_status_t status;
    logic [IW-1:0]          pos_addr;
    logic [IW-1:0]          acc_addr;

    // sequencer
    ppfs_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_last_particle (s_last_particle),
        .s_ready         (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .status          (status),
        .cmd             (cmd),
        .pos_addr        (pos_addr),
        .acc_addr        (acc_addr)
    );

    // arithmetic, stores and output register
    ppfs_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_position         (s_position),
        .cmd                (cmd),
        .pos_addr           (pos_addr),
        .acc_addr           (acc_addr),
        .status             (status),
        .m_particle_index   (m_particle_index),
        .m_force_res        (m_force_res),
        .m_saturated        (m_saturated),
        .m_coincident_error (m_coincident_error),
        .m_last_force       (m_last_force)
    );

endmodule
